@@ rtl/fcdma_pkg.sv @@
package fcdma_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
	localparam logic [CH_W-1:0] ROM_GUARD_CH = '0;
	localparam logic [CH_W-1:0] FIFO_CH_FIRST = CH_W'(1);
	localparam logic [CH_W-1:0] FIFO_CH_SECOND = CH_W'(2);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [27:0] SRC_MASK = 28'hFFF_FFFE;
	localparam logic [27:0] ROM_LO = 28'h800_0000;
	localparam logic [27:0] ROM_HI = 28'hE00_0000;
	localparam logic [27:0] DST_MASK_LOW = 28'h7FF_FFFF;
	localparam logic [15:0] CNT_MASK_LOW = 16'h3FFF;
	localparam logic [16:0] CNT_MAX_LOW = 17'd16384;
	localparam logic [16:0] CNT_MAX_HIGH = 17'd65536;
	localparam logic [16:0] FIFO_BURST = 17'd4;
	localparam logic [31:0] FIFO_A_ADDR = 32'h0400_00A0;
	localparam logic [31:0] FIFO_B_ADDR = 32'h0400_00A4;
	localparam logic [3:0] REGION_ZERO = 4'hE;
	localparam logic [3:0] REGION_OPEN = 4'h2;

	typedef enum logic [2:0] {
		OP_SRC    = 3'd0,
		OP_DST    = 3'd1,
		OP_CNT    = 3'd2,
		OP_CTL    = 3'd3,
		OP_VBLANK = 3'd4,
		OP_HBLANK = 3'd5,
		OP_FIFO   = 3'd6,
		OP_TICK   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		AM_INC        = 2'd0,
		AM_DEC        = 2'd1,
		AM_FIXED      = 2'd2,
		AM_INC_RELOAD = 2'd3
	} addr_mode_t;

	typedef enum logic [1:0] {
		TM_IMMEDIATE = 2'd0,
		TM_VBLANK    = 2'd1,
		TM_HBLANK    = 2'd2,
		TM_SPECIAL   = 2'd3
	} timing_t;

	typedef enum logic [1:0] {
		RK_MEMORY   = 2'd0,
		RK_ZERO     = 2'd1,
		RK_OPEN_BUS = 2'd2
	} read_kind_t;

	typedef struct packed {
		logic       enable;
		logic       irq;
		timing_t    timing;
		logic       wide;
		logic       rpt;
		addr_mode_t src_mode;
		addr_mode_t dest_mode;
	} ctl_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] channel;
		logic [27:0]     data;
		ctl_t            ctl;
		logic            fifo_sel;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [27:0]     src_addr;
		logic [31:0]     dst_addr;
		logic            wide;
		read_kind_t      kind;
		logic            last;
		logic            irq;
	} unit_t;

	function automatic logic [31:0] align_addr(input logic wide, input logic [31:0] a);
		return wide ? {a[31:2], 2'b00} : {a[31:1], 1'b0};
	endfunction

	function automatic logic [16:0] reload_count(input logic [CH_W-1:0] ch,
			input logic [15:0] cnt);
		logic [16:0] r;
		if (cnt == '0) begin
			r = (ch == LAST_CH) ? CNT_MAX_HIGH : CNT_MAX_LOW;
		end else begin
			r = {1'b0, cnt};
		end
		return r;
	endfunction

endpackage

@@ rtl/fcdma_front.sv @@
module fcdma_front (
	input  logic [47:0]         tdata,
	input  logic [2:0]          tuser,
	output fcdma_pkg::cmd_t     cmd
);
	import fcdma_pkg::*;

	logic [CH_W-1:0] ch;
	logic [31:0]     value;
	logic [27:0]     src_m;
	op_t             op;

	assign op    = op_t'(tuser);
	assign ch    = tdata[1:0];
	assign value = tdata[33:2];
	assign src_m = value[27:0] & SRC_MASK;

	always_comb begin
		cmd.op       = op;
		cmd.channel  = ch;
		cmd.fifo_sel = tdata[34];
		cmd.ctl.dest_mode = addr_mode_t'(tdata[36:35]);
		cmd.ctl.src_mode  = addr_mode_t'(tdata[38:37]);
		cmd.ctl.rpt       = tdata[39];
		cmd.ctl.wide      = tdata[40];
		cmd.ctl.timing    = timing_t'(tdata[42:41]);
		cmd.ctl.irq       = tdata[43];
		cmd.ctl.enable    = tdata[44];
		case (op)
			OP_SRC: begin
				// channel 0 cannot read from cartridge space
				if (ch == ROM_GUARD_CH && src_m >= ROM_LO && src_m < ROM_HI) begin
					cmd.data = '0;
				end else begin
					cmd.data = src_m;
				end
			end
			OP_DST: begin
				cmd.data = (ch == LAST_CH) ? value[27:0] : (value[27:0] & DST_MASK_LOW);
			end
			OP_CNT: begin
				cmd.data = {12'd0, (ch == LAST_CH) ? value[15:0] : (value[15:0] & CNT_MASK_LOW)};
			end
			default: begin
				cmd.data = value[27:0];
			end
		endcase
	end

endmodule

@@ rtl/fcdma_queue.sv @@
module fcdma_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fcdma_pkg::cmd_t push_cmd,
	output logic            full,
	output logic            not_empty,
	input  logic            pop,
	output fcdma_pkg::cmd_t head
);
	import fcdma_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/fcdma_back.sv @@
module fcdma_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  fcdma_pkg::cmd_t  cmd,
	output logic             cmd_pop,
	output logic             unit_valid,
	input  logic             unit_ready,
	output fcdma_pkg::unit_t unit
);
	import fcdma_pkg::*;

	logic [27:0] src_reg_q    [NUM_CHANNELS];
	logic [27:0] dst_reg_q    [NUM_CHANNELS];
	logic [15:0] cnt_reg_q    [NUM_CHANNELS];
	ctl_t        ctl_q        [NUM_CHANNELS];
	logic [31:0] run_src_q    [NUM_CHANNELS];
	logic [31:0] run_dst_q    [NUM_CHANNELS];
	logic [16:0] remain_q     [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] active_q;

	logic [27:0] src_reg_nx   [NUM_CHANNELS];
	logic [27:0] dst_reg_nx   [NUM_CHANNELS];
	logic [15:0] cnt_reg_nx   [NUM_CHANNELS];
	ctl_t        ctl_nx       [NUM_CHANNELS];
	logic [31:0] run_src_nx   [NUM_CHANNELS];
	logic [31:0] run_dst_nx   [NUM_CHANNELS];
	logic [16:0] remain_nx    [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] active_nx;

	logic                    unit_valid_q;
	unit_t                   unit_q;

	logic                    any_active;
	logic [CH_W-1:0]         pick;
	ctl_t                    t_ctl;
	logic [31:0]             t_size;
	logic [31:0]             t_s;
	logic [31:0]             t_d;
	logic [31:0]             t_s_next;
	logic [31:0]             t_d_next;
	logic [27:0]             t_eff;
	logic                    t_last;
	logic                    t_hold;
	read_kind_t              t_kind;
	logic [NUM_CHANNELS-1:0] fifo_ok;
	logic [31:0]             fifo_target;
	logic                    fire;
	logic                    emit;

	assign cmd_pop    = cmd_valid && (!unit_valid_q || unit_ready);
	assign fire       = cmd_pop;
	assign emit       = fire && cmd.op == OP_TICK && any_active;
	assign unit_valid = unit_valid_q;
	assign unit       = unit_q;

	// lowest-numbered active channel
	always_comb begin
		any_active = 1'b0;
		pick = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (active_q[i] && !any_active) begin
				any_active = 1'b1;
				pick = CH_W'(i);
			end
		end
	end

	always_comb begin
		t_ctl  = ctl_q[pick];
		t_size = t_ctl.wide ? 32'd4 : 32'd2;
		t_s    = align_addr(t_ctl.wide, run_src_q[pick]);
		t_d    = align_addr(t_ctl.wide, run_dst_q[pick]);
		t_eff  = t_s[27:0] & SRC_MASK;
		t_last = remain_q[pick] <= 17'd1;
		t_hold = t_ctl.rpt && t_ctl.timing != TM_IMMEDIATE;
		if (pick == ROM_GUARD_CH && t_eff[27:24] >= REGION_ZERO) begin
			t_kind = RK_ZERO;
		end else if (t_eff[27:24] < REGION_OPEN) begin
			t_kind = RK_OPEN_BUS;
		end else begin
			t_kind = RK_MEMORY;
		end
		case (t_ctl.src_mode)
			AM_DEC:   t_s_next = t_s - t_size;
			AM_FIXED: t_s_next = t_s;
			default:  t_s_next = t_s + t_size;
		endcase
		if (t_d == FIFO_A_ADDR || t_d == FIFO_B_ADDR) begin
			t_d_next = t_d;
		end else begin
			case (t_ctl.dest_mode)
				AM_DEC:   t_d_next = t_d - t_size;
				AM_FIXED: t_d_next = t_d;
				default:  t_d_next = t_d + t_size;
			endcase
		end
	end

	always_comb begin
		fifo_target = cmd.fifo_sel ? FIFO_B_ADDR : FIFO_A_ADDR;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			fifo_ok[i] = ctl_q[i].enable && !active_q[i] && ctl_q[i].timing == TM_SPECIAL
				&& {4'd0, dst_reg_q[i]} == fifo_target;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			src_reg_nx[i] = src_reg_q[i];
			dst_reg_nx[i] = dst_reg_q[i];
			cnt_reg_nx[i] = cnt_reg_q[i];
			ctl_nx[i]     = ctl_q[i];
			run_src_nx[i] = run_src_q[i];
			run_dst_nx[i] = run_dst_q[i];
			remain_nx[i]  = remain_q[i];
			active_nx[i]  = active_q[i];
			if (fire) begin
				case (cmd.op)
					OP_SRC: begin
						if (cmd.channel == CH_W'(i)) begin
							src_reg_nx[i] = cmd.data;
							run_src_nx[i] = {4'd0, cmd.data};
						end
					end
					OP_DST: begin
						if (cmd.channel == CH_W'(i)) begin
							dst_reg_nx[i] = cmd.data;
						end
					end
					OP_CNT: begin
						if (cmd.channel == CH_W'(i)) begin
							cnt_reg_nx[i] = cmd.data[15:0];
						end
					end
					OP_CTL: begin
						if (cmd.channel == CH_W'(i)) begin
							ctl_nx[i] = cmd.ctl;
							if (!ctl_q[i].enable && cmd.ctl.enable) begin
								run_src_nx[i] = align_addr(cmd.ctl.wide, {4'd0, src_reg_q[i]});
								run_dst_nx[i] = align_addr(cmd.ctl.wide, {4'd0, dst_reg_q[i]});
								remain_nx[i]  = reload_count(CH_W'(i), cnt_reg_q[i]);
								active_nx[i]  = cmd.ctl.timing == TM_IMMEDIATE;
							end else if (ctl_q[i].enable && !cmd.ctl.enable) begin
								active_nx[i] = 1'b0;
							end
						end
					end
					OP_VBLANK: begin
						if (ctl_q[i].enable && ctl_q[i].rpt && ctl_q[i].timing == TM_HBLANK) begin
							run_src_nx[i] = {4'd0, src_reg_q[i]};
							remain_nx[i]  = reload_count(CH_W'(i), cnt_reg_q[i]);
						end
						if (ctl_q[i].enable && !active_q[i] && ctl_q[i].timing == TM_VBLANK) begin
							active_nx[i] = 1'b1;
						end
					end
					OP_HBLANK: begin
						if (ctl_q[i].enable && !active_q[i] && ctl_q[i].timing == TM_HBLANK) begin
							active_nx[i] = 1'b1;
						end
					end
					OP_FIFO: begin
						if ((CH_W'(i) == FIFO_CH_FIRST && fifo_ok[FIFO_CH_FIRST])
								|| (CH_W'(i) == FIFO_CH_SECOND && fifo_ok[FIFO_CH_SECOND]
								&& !fifo_ok[FIFO_CH_FIRST])) begin
							remain_nx[i] = FIFO_BURST;
							active_nx[i] = 1'b1;
						end
					end
					OP_TICK: begin
						if (any_active && pick == CH_W'(i)) begin
							run_src_nx[i] = t_s_next;
							run_dst_nx[i] = t_d_next;
							if (t_last) begin
								if (t_hold) begin
									run_dst_nx[i] = {4'd0, dst_reg_q[i]};
									remain_nx[i]  = reload_count(CH_W'(i), cnt_reg_q[i]);
								end else begin
									remain_nx[i]     = '0;
									ctl_nx[i].enable = 1'b0;
								end
								active_nx[i] = 1'b0;
							end else begin
								remain_nx[i] = remain_q[i] - 17'd1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				src_reg_q[i] <= '0;
				dst_reg_q[i] <= '0;
				cnt_reg_q[i] <= '0;
				ctl_q[i]     <= '0;
				run_src_q[i] <= '0;
				run_dst_q[i] <= '0;
				remain_q[i]  <= '0;
			end
			active_q     <= '0;
			unit_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				src_reg_q[i] <= src_reg_nx[i];
				dst_reg_q[i] <= dst_reg_nx[i];
				cnt_reg_q[i] <= cnt_reg_nx[i];
				ctl_q[i]     <= ctl_nx[i];
				run_src_q[i] <= run_src_nx[i];
				run_dst_q[i] <= run_dst_nx[i];
				remain_q[i]  <= remain_nx[i];
			end
			active_q     <= active_nx;
			unit_valid_q <= emit || (unit_valid_q && !unit_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			unit_q.channel  <= pick;
			unit_q.src_addr <= t_eff;
			unit_q.dst_addr <= t_d;
			unit_q.wide     <= t_ctl.wide;
			unit_q.kind     <= t_kind;
			unit_q.last     <= t_last;
			unit_q.irq      <= t_last && t_ctl.irq;
		end
	end

endmodule

@@ rtl/four_channel_dma_address_engine_top.sv @@
// Four-channel DMA address engine. Each input item is a register write, a
// start trigger or a tick; a tick that finds an active channel yields one
// transfer unit of the lowest-numbered active channel, other items yield none.
// Items enter a two-entry queue and are carried out by the channel execution
// stage at one item per cycle while no result waits on a stalled sink; a
// result is registered and shows up on the output in the cycle after its item
// is taken. The output register holds a result while the sink stalls, and the
// queue keeps taking items until it is full. No clearing pass follows reset.
module four_channel_dma_address_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// channel, write_value, fifo_select, ctl_dest_mode, ctl_src_mode, ctl_repeat,
	// ctl_wide, ctl_timing, ctl_irq, ctl_enable, zero pad
	input  logic [47:0] s_axis_tdata,
	// op
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// unit_channel, src_addr, dst_addr, unit_wide, irq_request
	output logic [63:0] m_axis_tdata,
	// read_kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import fcdma_pkg::*;

	cmd_t  in_cmd;
	cmd_t  head_cmd;
	unit_t unit;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;

	fcdma_front u_front (
		.tdata (s_axis_tdata),
		.tuser (s_axis_tuser),
		.cmd   (in_cmd)
	);

	fcdma_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_cmd  (in_cmd),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (head_cmd)
	);

	fcdma_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_not_empty),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.unit_valid (m_axis_tvalid),
		.unit_ready (m_axis_tready),
		.unit       (unit)
	);

	assign s_axis_tready = !q_full;
	assign m_axis_tdata  = {unit.irq, unit.wide, unit.dst_addr, unit.src_addr, unit.channel};
	assign m_axis_tuser  = unit.kind;
	assign m_axis_tlast  = unit.last;

endmodule
